@@ rtl/dpmn_pkg.sv @@
package dpmn_pkg;

    // Widths of the two divisions
    localparam int DDEN_W      = 23;    // link * lanes
    localparam int LDEN_W      = 20;    // link
    localparam int Q_W         = 32;    // quotient bits, larger values flag an error

    // Divider pipeline shape
    localparam int DIV_STAGES  = 8;
    localparam int STEPS_PER   = Q_W / DIV_STAGES;

    // Ratio constants
    localparam logic [23:0] MN_LIMIT   = 24'hFFFFFF;
    localparam logic [27:0] DATA_N_INI = 28'h8000000;
    localparam logic [19:0] LINK_N_INI = 20'h80000;
    localparam logic [5:0]  TU_SIZE    = 6'd63;

    localparam int IN_W  = 56;
    localparam int OUT_W = 104;

endpackage

@@ rtl/dpmn_div_slice.sv @@
// Several restoring division steps, one register at the end.
module dpmn_div_slice
    import dpmn_pkg::*;
#(
    parameter int DEN_W = 20,
    parameter int STEPS = 4
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [DEN_W-1:0] den_in,
    input  logic [DEN_W-1:0] rem_in,
    input  logic [Q_W-1:0]   qn_in,
    output logic [DEN_W-1:0] den_reg,
    output logic [DEN_W-1:0] rem_reg,
    output logic [Q_W-1:0]   qn_reg
);

    logic [DEN_W-1:0] rem_next;
    logic [Q_W-1:0]   qn_next;

    // Shift in one numerator bit per step, subtract when it fits
    always_comb
    begin
        logic [DEN_W:0] trial;
        logic           fits;
        rem_next = rem_in;
        qn_next  = qn_in;
        for (int i = 0; i < STEPS; i++)
        begin
            trial = {rem_next, qn_next[Q_W-1]};
            fits  = (trial >= {1'b0, den_in});
            if (fits)
                trial = trial - {1'b0, den_in};
            rem_next = trial[DEN_W-1:0];
            qn_next  = {qn_next[Q_W-2:0], fits};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg <= den_in;
            rem_reg <= rem_next;
            qn_reg  <= qn_next;
        end
    end

endmodule

@@ rtl/dpmn_reduce.sv @@
// Shift an M/N pair right until both fit in 24 bits.
module dpmn_reduce
    import dpmn_pkg::*;
#(
    parameter int N_W = 28
)
(
    input  logic [Q_W-1:0] m_in,
    input  logic [N_W-1:0] n_ini,
    output logic [23:0]    m_out,
    output logic [23:0]    n_out
);

    localparam int NSH = N_W - 24;

    logic [3:0]     sh_m;
    logic [3:0]     sh;
    logic [Q_W-1:0] m_sh;
    logic [N_W-1:0] n_sh;

    // Bits of M above the 24-bit limit
    always_comb
    begin
        sh_m = 4'd0;
        for (int b = 24; b < Q_W; b++)
        begin
            if (m_in[b])
                sh_m = 4'(b - 23);
        end
        sh   = (sh_m > 4'(NSH)) ? sh_m : 4'(NSH);
        m_sh = m_in >> sh;
        n_sh = n_ini >> sh;
    end

    assign m_out = m_sh[23:0];
    assign n_out = n_sh[23:0];

endmodule

@@ rtl/dp_link_m_n_calculator.sv @@
// DisplayPort M/N calculator. Each request yields the data M/N pair
// (bpp * pclk * 2^27 / (8 * link * lanes)) and the link M/N pair
// (pclk * 2^19 / link), each reduced to 24 bits, plus the transfer unit
// size 63 in data M bits 25-30. A zero link rate or lane count, or a
// quotient of 2^32 or more, sets error_flag and zeroes all other fields.
// Both divisions run in an 8-stage restoring divider pipeline, four
// quotient bits per stage, between the product stage and the output
// register; a new request is taken every cycle while the output is not
// stalled.
module dp_link_m_n_calculator
    import dpmn_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // pixel_clock_khz[19:0], link_rate_khz[39:20], lane_count[42:40],
    // bits_per_pixel[48:43], zero fill
    input  logic [IN_W-1:0]  s_axis_tdata,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // data_m_word[30:0], data_n_value[54:31], link_m_value[78:55],
    // link_n_value[102:79], error_flag[103]
    output logic [OUT_W-1:0] m_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready
);

    logic en;

    // Whole pipeline advances together when the output slot frees
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // Stage 0: products
    logic [19:0]     pclk_in;
    logic [19:0]     link_in;
    logic [2:0]      lanes_in;
    logic [5:0]      bpp_in;
    logic [25:0]     dnum_reg;
    logic [DDEN_W-1:0] dden_reg;
    logic [19:0]     pclk_reg;
    logic [LDEN_W-1:0] lden_reg;
    logic            v0_reg;

    assign pclk_in  = s_axis_tdata[19:0];
    assign link_in  = s_axis_tdata[39:20];
    assign lanes_in = s_axis_tdata[42:40];
    assign bpp_in   = s_axis_tdata[48:43];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dnum_reg <= 26'(bpp_in) * 26'(pclk_in);
            dden_reg <= 23'(link_in) * 23'(lanes_in);
            pclk_reg <= pclk_in;
            lden_reg <= link_in;
        end
    end

    // Numerators: data bpp*pclk*2^24, link pclk*2^19; high parts from bit 32 up
    logic [DDEN_W-1:0] drem0;
    logic [LDEN_W-1:0] lrem0;
    logic [Q_W-1:0]    dqn0;
    logic [Q_W-1:0]    lqn0;
    logic              err0;

    assign drem0 = DDEN_W'(dnum_reg[25:8]);
    assign dqn0  = {dnum_reg[7:0], 24'd0};
    assign lrem0 = LDEN_W'(pclk_reg[19:13]);
    assign lqn0  = {pclk_reg[12:0], 19'd0};
    assign err0  = (dden_reg == '0) || (lden_reg == '0) ||
                   (DDEN_W'(dnum_reg[25:8]) >= dden_reg) ||
                   (LDEN_W'(pclk_reg[19:13]) >= lden_reg);

    // Divider stages
    logic [DDEN_W-1:0] dden_s [0:DIV_STAGES];
    logic [DDEN_W-1:0] drem_s [0:DIV_STAGES];
    logic [Q_W-1:0]    dqn_s  [0:DIV_STAGES];
    logic [LDEN_W-1:0] lden_s [0:DIV_STAGES];
    logic [LDEN_W-1:0] lrem_s [0:DIV_STAGES];
    logic [Q_W-1:0]    lqn_s  [0:DIV_STAGES];
    logic              err_reg [1:DIV_STAGES];
    logic              v_reg   [1:DIV_STAGES];

    assign dden_s[0] = dden_reg;
    assign drem_s[0] = drem0;
    assign dqn_s[0]  = dqn0;
    assign lden_s[0] = lden_reg;
    assign lrem_s[0] = lrem0;
    assign lqn_s[0]  = lqn0;

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        dpmn_div_slice #(.DEN_W(DDEN_W), .STEPS(STEPS_PER)) u_ddiv (
            .clk     (clk),
            .en      (en),
            .den_in  (dden_s[g]),
            .rem_in  (drem_s[g]),
            .qn_in   (dqn_s[g]),
            .den_reg (dden_s[g+1]),
            .rem_reg (drem_s[g+1]),
            .qn_reg  (dqn_s[g+1])
        );
        dpmn_div_slice #(.DEN_W(LDEN_W), .STEPS(STEPS_PER)) u_ldiv (
            .clk     (clk),
            .en      (en),
            .den_in  (lden_s[g]),
            .rem_in  (lrem_s[g]),
            .qn_in   (lqn_s[g]),
            .den_reg (lden_s[g+1]),
            .rem_reg (lrem_s[g+1]),
            .qn_reg  (lqn_s[g+1])
        );
    end

    // Error and valid travel alongside
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            err_reg[1] <= err0;
            for (int i = 2; i <= DIV_STAGES; i++)
                err_reg[i] <= err_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            for (int i = 1; i <= DIV_STAGES; i++)
                v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v0_reg   <= s_axis_tvalid;
            v_reg[1] <= v0_reg;
            for (int i = 2; i <= DIV_STAGES; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    // Reduction into the output register
    logic [23:0]      dm;
    logic [23:0]      dn;
    logic [23:0]      lm;
    logic [23:0]      ln;
    logic [OUT_W-1:0] out_next;
    logic [OUT_W-1:0] out_reg;
    logic             ovalid_reg;

    dpmn_reduce #(.N_W(28)) u_dred (
        .m_in  (dqn_s[DIV_STAGES]),
        .n_ini (DATA_N_INI),
        .m_out (dm),
        .n_out (dn)
    );

    dpmn_reduce #(.N_W(24)) u_lred (
        .m_in  (lqn_s[DIV_STAGES]),
        .n_ini (24'(LINK_N_INI)),
        .m_out (lm),
        .n_out (ln)
    );

    always_comb
    begin
        if (err_reg[DIV_STAGES])
            out_next = {1'b1, 103'd0};
        else
            out_next = {1'b0, ln, lm, dn, TU_SIZE, 1'b0, dm};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (en)
            ovalid_reg <= v_reg[DIV_STAGES];
    end

    assign m_axis_tdata  = out_reg;
    assign m_axis_tvalid = ovalid_reg;

endmodule
